FILE: hw/rtl/tdpc_pkg.sv
`timescale 1ns / 1ps

package tdpc_pkg;

    // Default operand width and fixed result widths
    localparam int NUMBER_BITS_DEF = 16;
    localparam int PRIME_W         = 16;
    localparam int DIV_W           = 32;

    // Lowest divisor tried, and the operand below which nothing is tested
    localparam int FIRST_DIVISOR   = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XSTART,
        ST_TEST,
        ST_DIVWAIT,
        ST_ADVANCE,
        ST_DONE
    } state_t;

    // Remainder unit status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic rem_zero;
    } div_status_t;

endpackage

FILE: hw/rtl/trial_division_prime_counter_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
//  channel  dir  ports                                   beat
//  s_       in   s_valid s_ready s_range_start/end       one range request
//  m_       out  m_valid m_ready m_prime_count           one result
//                m_division_count
// ---------------------------------------------------------------------------
// One request at a time; s_ready is high only while the sequencer is idle.
// The single bit-serial remainder unit sets the pace: each x >= 2 in the range
// is divided by successive divisors from 2 up to sqrt(x), stopping at the first
// one that leaves no remainder; x is prime when none up to sqrt(x) divides it.
// aresetn is synchronous, active low; it clears the sequencer and m_valid.
// A finished result sits in the output register; a new request is taken
// while it waits, and the sequencer stalls in ST_DONE only if the next
// result is ready before the old one is taken.
// ---------------------------------------------------------------------------
module trial_division_prime_counter_unit #(
    parameter int NUMBER_BITS = tdpc_pkg::NUMBER_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [NUMBER_BITS-1:0]       s_range_start,
    input  logic [NUMBER_BITS-1:0]       s_range_end,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tdpc_pkg::PRIME_W-1:0] m_prime_count,
    output logic [tdpc_pkg::DIV_W-1:0]   m_division_count
);

    localparam int NB = NUMBER_BITS;
    localparam int PW = tdpc_pkg::PRIME_W;
    localparam int DW = tdpc_pkg::DIV_W;

    tdpc_pkg::state_t state_reg, state_next;

    // working registers
    logic [NB-1:0]  x_reg;         // number under test
    logic [NB-1:0]  hi_reg;        // last number of the range
    logic [NB-1:0]  d_reg;         // current divisor
    logic [NB:0]    sq_reg;        // d_reg squared, kept incrementally
    logic [NB-1:0]  add_reg;       // divisions charged to x_reg
    logic           prime_reg;     // x_reg found prime
    logic [PW-1:0]  primes_reg;
    logic [DW-1:0]  divs_reg;

    // output register
    logic           m_valid_reg;
    logic [PW-1:0]  m_prime_reg;
    logic [DW-1:0]  m_divs_reg;

    logic           s_accept;
    logic           div_start;
    logic           out_load;
    logic           sq_above_x;
    logic           x_small;
    logic [DW:0]    divs_sum;

    tdpc_pkg::div_status_t div_stat;

    tdpc_div #(
        .NB (NB)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (x_reg),
        .divisor  (d_reg),
        .status   (div_stat)
    );

    assign s_accept   = s_valid && s_ready;
    assign sq_above_x = (sq_reg > {1'b0, x_reg});
    assign x_small    = (x_reg < NB'(tdpc_pkg::FIRST_DIVISOR));
    assign divs_sum   = {1'b0, divs_reg} + (DW+1)'(add_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tdpc_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_range_start > s_range_end) ? tdpc_pkg::ST_DONE
                                                               : tdpc_pkg::ST_XSTART;
                end
            end
            tdpc_pkg::ST_XSTART: begin
                state_next = x_small ? tdpc_pkg::ST_ADVANCE : tdpc_pkg::ST_TEST;
            end
            tdpc_pkg::ST_TEST: begin
                state_next = sq_above_x ? tdpc_pkg::ST_ADVANCE : tdpc_pkg::ST_DIVWAIT;
            end
            tdpc_pkg::ST_DIVWAIT: begin
                if (div_stat.done) begin
                    state_next = div_stat.rem_zero ? tdpc_pkg::ST_ADVANCE
                                                   : tdpc_pkg::ST_TEST;
                end
            end
            tdpc_pkg::ST_ADVANCE: begin
                state_next = (x_reg == hi_reg) ? tdpc_pkg::ST_DONE : tdpc_pkg::ST_XSTART;
            end
            tdpc_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = tdpc_pkg::ST_IDLE;
                end
            end
            default: state_next = tdpc_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            tdpc_pkg::ST_IDLE: s_ready   = 1'b1;
            tdpc_pkg::ST_TEST: div_start = !sq_above_x;
            tdpc_pkg::ST_DONE: out_load  = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdpc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            tdpc_pkg::ST_IDLE: begin
                x_reg      <= s_range_start;
                hi_reg     <= s_range_end;
                primes_reg <= '0;
                divs_reg   <= '0;
            end
            tdpc_pkg::ST_XSTART: begin
                d_reg     <= NB'(tdpc_pkg::FIRST_DIVISOR);
                sq_reg    <= (NB+1)'(tdpc_pkg::FIRST_DIVISOR * tdpc_pkg::FIRST_DIVISOR);
                add_reg   <= '0;
                prime_reg <= 1'b0;
            end
            tdpc_pkg::ST_TEST: begin
                if (sq_above_x) begin
                    // no factor up to sqrt(x): prime, full search cost
                    add_reg   <= x_reg - NB'(tdpc_pkg::FIRST_DIVISOR);
                    prime_reg <= 1'b1;
                end
            end
            tdpc_pkg::ST_DIVWAIT: begin
                if (div_stat.done) begin
                    if (div_stat.rem_zero) begin
                        add_reg <= d_reg - 1'b1;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_reg <= sq_reg + {d_reg, 1'b1};
                        d_reg  <= d_reg + 1'b1;
                    end
                end
            end
            tdpc_pkg::ST_ADVANCE: begin
                divs_reg <= divs_sum[DW] ? '1 : divs_sum[DW-1:0];
                if (prime_reg && (primes_reg != '1)) begin
                    primes_reg <= primes_reg + 1'b1;
                end
                x_reg <= x_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_prime_reg <= primes_reg;
            m_divs_reg  <= divs_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_prime_count    = m_prime_reg;
    assign m_division_count = m_divs_reg;

`ifndef SYNTH
    // remainder unit is never restarted mid-operation
    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("remainder unit started while busy");

    // the incremental square tracks the divisor
    a_square_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tdpc_pkg::ST_TEST) |->
        ((2*NB)'(sq_reg) == (2*NB)'(d_reg) * (2*NB)'(d_reg)))
        else $error("divisor square out of step");

    // a request is taken only from idle, and the sequencer leaves idle at once
    a_ready_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("ready held after accepting a request");

    // a new result appears only out of the finish state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == tdpc_pkg::ST_DONE))
        else $error("result raised outside finish state");
`endif

endmodule

FILE: hw/rtl/tdpc_div.sv
`timescale 1ns / 1ps

// Restoring remainder unit: one quotient bit per cycle, a shift step for each
// dividend bit after start, done flagged for one cycle right after the last step.
module tdpc_div #(
    parameter int NB = tdpc_pkg::NUMBER_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [NB-1:0]         dividend,
    input  logic [NB-1:0]         divisor,
    output tdpc_pkg::div_status_t status
);

    localparam int CNT_W = $clog2(NB);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NB-1:0]    rem_reg;
    logic [NB-1:0]    shf_reg;
    logic [NB-1:0]    dvsr_reg;

    logic [NB:0]      trial;
    logic             fits;
    logic [NB-1:0]    rem_next;

    assign trial    = {rem_reg, shf_reg[NB-1]};
    assign fits     = (trial >= {1'b0, dvsr_reg});
    assign rem_next = fits ? NB'(trial - {1'b0, dvsr_reg}) : trial[NB-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == '0)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shf_reg  <= dividend;
            dvsr_reg <= divisor;
            rem_reg  <= '0;
            cnt_reg  <= CNT_W'(NB - 1);
        end else if (busy_reg) begin
            shf_reg <= {shf_reg[NB-2:0], 1'b0};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign status.rem_zero = (rem_reg == '0);

endmodule
